### design/cate_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cate_pkg;

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_EVICT  = 1'b1;

	localparam logic [1:0] TIER_COLD = 2'd0;
	localparam logic [1:0] TIER_WARM = 2'd1;
	localparam logic [1:0] TIER_HOT  = 2'd2;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_INSERT  = 2'd1;
	localparam logic [1:0] ACT_MOVE    = 2'd2;
	localparam logic [1:0] ACT_PROMOTE = 2'd3;

	localparam logic [1:0] LVL_LOW  = 2'd0;
	localparam logic [1:0] LVL_MED  = 2'd1;
	localparam logic [1:0] LVL_HIGH = 2'd2;

	localparam logic REG_HIGH_LEVEL = 1'b0;
	localparam logic REG_LOW_LEVEL  = 1'b1;

	localparam logic [9:0] HIGH_LEVEL_RST = 10'd700;
	localparam logic [9:0] LOW_LEVEL_RST  = 10'd300;
	localparam logic [9:0] SCORE_MAX      = 10'd1000;

	localparam logic [47:0] COLD_AGE_HIGH = 48'd1000000000;
	localparam logic [47:0] COLD_AGE_MED  = 48'd500000000;
	localparam logic [47:0] COLD_AGE_LOW  = 48'd200000000;
	localparam logic [47:0] WARM_AGE_LOW  = 48'd300000000;
	localparam logic [32:0] WARM_BASE     = 33'd1000000000;
	localparam logic [19:0] WARM_STEP     = 20'd1000000;
	localparam logic [26:0] HOT_BASE      = 27'd100000000;
	// floor(score / 10) = (score * 205) >> 11 for score up to 1023
	localparam logic [7:0]  DIV10_MUL     = 8'd205;

	typedef struct packed {
		logic        evict;
		logic [1:0]  next_tier;
		logic [15:0] new_count;
		logic [1:0]  list_action;
	} cate_res_t;

endpackage

`default_nettype wire

### design/congestion_adaptive_tier_eviction.sv
// channel | handshake            | payload
// in      | in_valid / in_ready  | cmd, link metrics, tier, hit_count, age_ns, busy_req
// out     | out_valid / out_ready| evict, congestion_score, next_tier, new_count, list_action
// cfg     | psel/penable/pwrite  | paddr[2:0], pwdata, prdata, pready (always high)
//
// One item per cycle sustained while out_ready is high; each item passes the score stage, then the decision stage.
// The score stage registers the congestion score; the decision stage holds the result.
// Reset clears both stage valids and loads the level registers with 700 and 300.
// A stalled output holds the result stage; the score stage refills while that slot drains.
`timescale 1ns / 1ps
`default_nettype none

module congestion_adaptive_tier_eviction
	import cate_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [31:0] rtt_scaled,
	input  wire logic [31:0] jitter_scaled,
	input  wire logic [15:0] retrans_in_flight,
	input  wire logic [15:0] lost_segments,
	input  wire logic [31:0] lifetime_retrans,
	input  wire logic [15:0] in_flight,
	input  wire logic [15:0] window_segments,
	input  wire logic [1:0]  tier,
	input  wire logic [15:0] hit_count,
	input  wire logic [47:0] age_ns,
	input  wire logic        busy_req,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             evict,
	output logic      [9:0]  congestion_score,
	output logic      [1:0]  next_tier,
	output logic      [15:0] new_count,
	output logic      [1:0]  list_action,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [9:0]  high_level_q;
	logic [9:0]  low_level_q;

	logic        valid_s1;
	logic        cmd_s1;
	logic [1:0]  tier_s1;
	logic [15:0] count_s1;
	logic [47:0] age_s1;
	logic        busy_s1;
	logic [9:0]  score_s1;

	logic        valid_s2;
	logic [9:0]  score_s2;
	cate_res_t   res_s2;

	logic [9:0]  score_c;
	cate_res_t   res_c;
	logic        adv_s2;
	logic        take_in;

	assign pready   = 1'b1;
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_level_q <= HIGH_LEVEL_RST;
			low_level_q  <= LOW_LEVEL_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_HIGH_LEVEL: high_level_q <= pwdata[9:0];
				REG_LOW_LEVEL:  low_level_q  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HIGH_LEVEL: prdata = {22'd0, high_level_q};
			REG_LOW_LEVEL:  prdata = {22'd0, low_level_q};
			default:        prdata = 32'd0;
		endcase
	end

	cate_score u_score (
		.rtt_scaled        (rtt_scaled),
		.jitter_scaled     (jitter_scaled),
		.retrans_in_flight (retrans_in_flight),
		.lost_segments     (lost_segments),
		.lifetime_retrans  (lifetime_retrans),
		.in_flight         (in_flight),
		.window_segments   (window_segments),
		.score             (score_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1   <= cmd;
			tier_s1  <= tier;
			count_s1 <= hit_count;
			age_s1   <= age_ns;
			busy_s1  <= busy_req;
			score_s1 <= score_c;
		end
	end

	cate_decide u_decide (
		.cmd        (cmd_s1),
		.tier       (tier_s1),
		.hit_count  (count_s1),
		.age_ns     (age_s1),
		.busy_req   (busy_s1),
		.score      (score_s1),
		.high_level (high_level_q),
		.low_level  (low_level_q),
		.res        (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			score_s2 <= score_s1;
			res_s2   <= res_c;
		end
	end

	assign out_valid        = valid_s2;
	assign evict            = res_s2.evict;
	assign congestion_score = score_s2;
	assign next_tier        = res_s2.next_tier;
	assign new_count        = res_s2.new_count;
	assign list_action      = res_s2.list_action;

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (score_s2 <= SCORE_MAX))
		else $error("score above saturation limit");

	a_evict_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.evict |-> (res_s2.list_action == ACT_NONE && res_s2.new_count == 16'd0))
		else $error("eviction result carries access fields");

	a_access_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.list_action != ACT_NONE |-> res_s2.new_count != 16'd0)
		else $error("access result with zero count");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(score_s1))
		else $error("score stage lost an item under stall");

endmodule

`default_nettype wire

### design/cate_score.sv
`timescale 1ns / 1ps
`default_nettype none

module cate_score
	import cate_pkg::*;
(
	input  wire logic [31:0] rtt_scaled,
	input  wire logic [31:0] jitter_scaled,
	input  wire logic [15:0] retrans_in_flight,
	input  wire logic [15:0] lost_segments,
	input  wire logic [31:0] lifetime_retrans,
	input  wire logic [15:0] in_flight,
	input  wire logic [15:0] window_segments,
	output logic      [9:0]  score
);

	logic [28:0] rtt;
	logic [28:0] dev;
	logic [8:0]  rtt_pts;
	logic [8:0]  dev_pts;
	logic [7:0]  ret_pts;
	logic [7:0]  win_pts;
	logic [16:0] pout_x2;
	logic [17:0] pout_x3;
	logic [10:0] sum;

	assign rtt     = rtt_scaled[31:3];
	assign dev     = jitter_scaled[31:3];
	assign pout_x2 = {in_flight, 1'b0};
	assign pout_x3 = {1'b0, in_flight, 1'b0} + {2'b00, in_flight};

	always_comb begin
		if (rtt > 29'd100000)     rtt_pts = 9'd400;
		else if (rtt > 29'd50000) rtt_pts = 9'd300;
		else if (rtt > 29'd20000) rtt_pts = 9'd200;
		else if (rtt > 29'd5000)  rtt_pts = 9'd100;
		else                      rtt_pts = 9'd0;

		if (dev > 29'd20000)      dev_pts = 9'd250;
		else if (dev > 29'd10000) dev_pts = 9'd200;
		else if (dev > 29'd5000)  dev_pts = 9'd150;
		else if (dev > 29'd1000)  dev_pts = 9'd100;
		else                      dev_pts = 9'd0;

		if (retrans_in_flight > 16'd5 || lost_segments != 16'd0) ret_pts = 8'd200;
		else if (lifetime_retrans > 32'd10)                       ret_pts = 8'd150;
		else if (lifetime_retrans != 32'd0)                       ret_pts = 8'd50;
		else                                                      ret_pts = 8'd0;

		win_pts = 8'd0;
		if (in_flight != 16'd0 && window_segments != 16'd0) begin
			if (pout_x2 > {1'b0, window_segments})       win_pts = 8'd150;
			else if (pout_x3 > {2'b00, window_segments}) win_pts = 8'd100;
		end

		sum = {2'b00, rtt_pts} + {2'b00, dev_pts} + {3'b000, ret_pts} + {3'b000, win_pts};
		score = (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[9:0];
	end

endmodule

`default_nettype wire

### design/cate_decide.sv
`timescale 1ns / 1ps
`default_nettype none

module cate_decide
	import cate_pkg::*;
(
	input  wire logic        cmd,
	input  wire logic [1:0]  tier,
	input  wire logic [15:0] hit_count,
	input  wire logic [47:0] age_ns,
	input  wire logic        busy_req,
	input  wire logic [9:0]  score,
	input  wire logic [9:0]  high_level,
	input  wire logic [9:0]  low_level,
	output cate_res_t        res
);

	logic [1:0]  lvl;
	logic [32:0] ws;
	logic [33:0] ws_x2;
	logic [32:0] ws_half;
	logic [17:0] div_prod;
	logic [6:0]  score_div10;
	logic [26:0] rw;
	logic [28:0] rw_x2;
	logic [28:0] rw_x3;
	logic        ev;
	logic [15:0] cnt_inc;
	logic [2:0]  warm_at;
	logic [2:0]  hot_at;
	logic [1:0]  t;

	assign ws          = WARM_BASE + 33'(score) * 33'(WARM_STEP);
	assign ws_x2       = {ws, 1'b0};
	assign ws_half     = {1'b0, ws[32:1]};
	assign div_prod    = 18'(score) * 18'(DIV10_MUL);
	assign score_div10 = div_prod[17:11];
	assign rw          = HOT_BASE + 27'(score_div10);
	assign rw_x2       = {1'b0, rw, 1'b0};
	assign rw_x3       = rw_x2 + 29'(rw);

	always_comb begin
		if (score > high_level)     lvl = LVL_HIGH;
		else if (score > low_level) lvl = LVL_MED;
		else                        lvl = LVL_LOW;
	end

	always_comb begin
		ev = 1'b0;
		unique case (tier)
			TIER_COLD: begin
				if (lvl == LVL_HIGH)     ev = age_ns > COLD_AGE_HIGH;
				else if (lvl == LVL_MED) ev = age_ns > COLD_AGE_MED;
				else                     ev = age_ns > COLD_AGE_LOW;
			end
			TIER_WARM: begin
				if (lvl == LVL_HIGH)
					ev = (age_ns >= 48'(ws)) && (age_ns > 48'(ws_x2));
				else if (lvl == LVL_MED)
					ev = (age_ns >= 48'(ws_half)) && (age_ns > 48'(ws));
				else
					ev = age_ns > WARM_AGE_LOW;
			end
			default: begin
				if (lvl == LVL_HIGH)     ev = age_ns > 48'(rw_x3);
				else if (lvl == LVL_MED) ev = age_ns > 48'(rw_x2);
				else                     ev = age_ns > 48'(rw);
			end
		endcase
	end

	always_comb begin
		cnt_inc = (hit_count == 16'hFFFF) ? hit_count : hit_count + 16'd1;
		if (lvl == LVL_HIGH) begin
			warm_at = 3'd1;
			hot_at  = 3'd2;
		end else if (lvl == LVL_MED) begin
			warm_at = 3'd2;
			hot_at  = 3'd3;
		end else begin
			warm_at = 3'd3;
			hot_at  = 3'd6;
		end
		if (cnt_inc >= 16'(hot_at))       t = TIER_HOT;
		else if (cnt_inc >= 16'(warm_at)) t = TIER_WARM;
		else                              t = TIER_COLD;

		res = '0;
		if (cmd == CMD_EVICT) begin
			if (hit_count == 16'd0) res.evict = 1'b1;
			else if (busy_req)      res.evict = 1'b0;
			else                    res.evict = ev;
		end else if (hit_count == 16'd0) begin
			res.new_count   = 16'd1;
			res.next_tier   = TIER_COLD;
			res.list_action = ACT_INSERT;
		end else begin
			res.new_count   = cnt_inc;
			res.next_tier   = t;
			res.list_action = (t > tier) ? ACT_PROMOTE : ACT_MOVE;
		end
	end

endmodule

`default_nettype wire
